FILE: hw/rtl/slmp_rfp_pkg.sv
// ---------------------------------------------------------------------------
// SLMP response frame parser package
// Shared constants, register map, configuration and queue entry types.
// ---------------------------------------------------------------------------
package slmp_rfp_pkg;

    localparam int unsigned MAX_PACKET  = 1024;
    localparam int unsigned MAX_VALUES  = 960;
    localparam int unsigned HDR_LEN_3E  = 9;
    localparam int unsigned HDR_LEN_4E  = 13;
    localparam int unsigned LEN_AT_3E   = 7;
    localparam int unsigned LEN_AT_4E   = 11;

    localparam int unsigned FIFO_DEPTH  = 4;
    localparam int unsigned FIFO_AW     = $clog2(FIFO_DEPTH);

    localparam int unsigned APB_AW      = 5;
    localparam int unsigned APB_DW      = 32;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_SUB_3E       = 3'd0;
    localparam logic [2:0] REG_SUB_4E       = 3'd1;
    localparam logic [2:0] REG_EXP_SERIAL   = 3'd2;
    localparam logic [2:0] REG_REQ_COUNT    = 3'd3;
    localparam logic [2:0] REG_DEV_IS_BIT   = 3'd4;
    localparam logic [2:0] REG_BATCH_WRITE  = 3'd5;

    localparam logic [15:0] SUB_3E_RESET = 16'h00D0;
    localparam logic [15:0] SUB_4E_RESET = 16'h00D4;

    // Frame status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_RESP_ERR  = 2'd1;
    localparam logic [1:0] STATUS_BAD_COUNT = 2'd2;
    localparam logic [1:0] STATUS_HDR_BAD   = 2'd3;

    typedef struct packed {
        logic [15:0] sub_3e;
        logic [15:0] sub_4e;
        logic [15:0] exp_serial;
        logic [9:0]  req_count;
        logic        dev_is_bit;
        logic        batch_write;
    } cfg_t;

    // One entry per received byte that gives results: up to two data
    // values followed by an optional frame status.
    typedef struct packed {
        logic [1:0]  n_vals;
        logic        has_status;
        logic [1:0]  status;
        logic [9:0]  base_index;
        logic [15:0] v0;
        logic        v1;
        logic [15:0] end_code;
        logic        frame_type;
        logic [15:0] skipped;
    } ent_t;

endpackage

FILE: hw/rtl/slmp_rfp_regs.sv
// ---------------------------------------------------------------------------
// SLMP response parser configuration registers
// APB-style register file holding the subheaders, serial and request setup.
// ---------------------------------------------------------------------------
module slmp_rfp_regs
    import slmp_rfp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sub_3e      <= SUB_3E_RESET;
            cfg_reg.sub_4e      <= SUB_4E_RESET;
            cfg_reg.exp_serial  <= '0;
            cfg_reg.req_count   <= '0;
            cfg_reg.dev_is_bit  <= 1'b0;
            cfg_reg.batch_write <= 1'b0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_SUB_3E:      cfg_reg.sub_3e      <= pwdata[15:0];
                REG_SUB_4E:      cfg_reg.sub_4e      <= pwdata[15:0];
                REG_EXP_SERIAL:  cfg_reg.exp_serial  <= pwdata[15:0];
                REG_REQ_COUNT:   cfg_reg.req_count   <= pwdata[9:0];
                REG_DEV_IS_BIT:  cfg_reg.dev_is_bit  <= pwdata[0];
                REG_BATCH_WRITE: cfg_reg.batch_write <= pwdata[0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_SUB_3E:      prdata = {16'd0, cfg_reg.sub_3e};
            REG_SUB_4E:      prdata = {16'd0, cfg_reg.sub_4e};
            REG_EXP_SERIAL:  prdata = {16'd0, cfg_reg.exp_serial};
            REG_REQ_COUNT:   prdata = {22'd0, cfg_reg.req_count};
            REG_DEV_IS_BIT:  prdata = {31'd0, cfg_reg.dev_is_bit};
            REG_BATCH_WRITE: prdata = {31'd0, cfg_reg.batch_write};
            default:         prdata = '0;
        endcase
    end

endmodule

FILE: hw/rtl/slmp_rfp_front.sv
// ---------------------------------------------------------------------------
// SLMP response parser front end
// Byte-wide frame state machine: hunts, checks the header, reads the end
// code and classifies payload bytes into queue entries.
// ---------------------------------------------------------------------------
module slmp_rfp_front
    import slmp_rfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       accept,
    input  logic [7:0] rx_byte,
    output logic       push,
    output ent_t       push_ent
);

    typedef enum logic [1:0] {PH_HUNT, PH_HEADER, PH_CODE, PH_PAYLOAD} phase_t;

    localparam logic [3:0]  HL_3E     = 4'(HDR_LEN_3E);
    localparam logic [3:0]  HL_4E     = 4'(HDR_LEN_4E);
    localparam logic [3:0]  LA_3E     = 4'(LEN_AT_3E);
    localparam logic [3:0]  LA_4E     = 4'(LEN_AT_4E);
    localparam logic [3:0]  LA_3E_HI  = 4'(LEN_AT_3E + 1);
    localparam logic [3:0]  LA_4E_HI  = 4'(LEN_AT_4E + 1);
    localparam logic [15:0] MAX_PKT   = 16'(MAX_PACKET);
    localparam logic [9:0]  MAX_VALS  = 10'(MAX_VALUES);

    phase_t      phase_reg, phase_next;
    logic [7:0]  held_byte_reg, held_byte_next;
    logic        held_valid_reg, held_valid_next;
    logic [3:0]  hpos_reg, hpos_next;
    logic        four_reg, four_next;
    logic [15:0] serial_reg, serial_next;
    logic [15:0] flen_reg, flen_next;
    logic [15:0] pleft_reg, pleft_next;
    logic [15:0] code_reg, code_next;
    logic        bad_reg, bad_next;
    logic [9:0]  ve_reg, ve_next;
    logic [15:0] skip_reg, skip_next;

    logic [15:0] word;
    logic        is_low;
    logic [1:0]  skip_inc;
    logic [16:0] skip_sum;
    logic [3:0]  hl, la, la_hi;
    logic [4:0]  p_inc;
    logic [15:0] ser_w, flen_w, code_w, pl, pl_dec;
    logic        cnt_bad, bad_w, hdr_ok;
    logic [10:0] half_cnt;
    logic        first, second;
    logic [10:0] ve_plus1;

    always_comb
    begin
        phase_next      = phase_reg;
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        hpos_next       = hpos_reg;
        four_next       = four_reg;
        serial_next     = serial_reg;
        flen_next       = flen_reg;
        pleft_next      = pleft_reg;
        code_next       = code_reg;
        bad_next        = bad_reg;
        ve_next         = ve_reg;
        skip_next       = skip_reg;

        push                = 1'b0;
        push_ent            = '0;
        push_ent.base_index = ve_reg;
        push_ent.end_code   = code_reg;
        push_ent.frame_type = four_reg;
        push_ent.skipped    = skip_reg;

        word     = {rx_byte, held_byte_reg};
        is_low   = (rx_byte == cfg.sub_3e[7:0]) || (rx_byte == cfg.sub_4e[7:0]);
        skip_inc = {1'b0, held_valid_reg} + {1'b0, !is_low};
        skip_sum = {1'b0, skip_reg} + {15'd0, skip_inc};

        hl     = four_reg ? HL_4E : HL_3E;
        la     = four_reg ? LA_4E : LA_3E;
        la_hi  = four_reg ? LA_4E_HI : LA_3E_HI;
        p_inc  = {1'b0, hpos_reg} + 5'd1;
        ser_w  = serial_reg;
        flen_w = flen_reg;
        if (four_reg && hpos_reg == 4'd2)
            ser_w[7:0] = rx_byte;
        if (four_reg && hpos_reg == 4'd3)
            ser_w[15:8] = rx_byte;
        if (hpos_reg == la)
            flen_w[7:0] = rx_byte;
        if (hpos_reg == la_hi)
            flen_w[15:8] = rx_byte;
        hdr_ok = (!four_reg || ser_w == cfg.exp_serial) &&
                 (flen_w >= 16'd2) && (flen_w <= MAX_PKT);

        code_w   = {rx_byte, held_byte_reg};
        pl       = flen_reg - 16'd2;
        cnt_bad  = (cfg.req_count == 10'd0) || (cfg.req_count > MAX_VALS);
        half_cnt = ({1'b0, cfg.req_count} + 11'd1) >> 1;
        if (code_w != 16'd0)
            bad_w = 1'b0;
        else if (cfg.batch_write)
            bad_w = (pl != 16'd0);
        else if (cfg.dev_is_bit)
            bad_w = cnt_bad || (pl < {6'd0, half_cnt[9:0]});
        else
            bad_w = pl[0] || cnt_bad || (pl != {5'd0, cfg.req_count, 1'b0});

        pl_dec   = pleft_reg - 16'd1;
        ve_plus1 = {1'b0, ve_reg} + 11'd1;
        first    = (ve_reg < cfg.req_count);
        second   = first && (ve_plus1 < {1'b0, cfg.req_count});

        if (accept)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (held_valid_reg && (word == cfg.sub_4e || word == cfg.sub_3e))
                    begin
                        // The 4E subheader takes precedence over the 3E one.
                        four_next       = (word == cfg.sub_4e);
                        held_valid_next = 1'b0;
                        hpos_next       = 4'd2;
                        serial_next     = '0;
                        flen_next       = '0;
                        code_next       = '0;
                        pleft_next      = '0;
                        bad_next        = 1'b0;
                        ve_next         = '0;
                        phase_next      = PH_HEADER;
                    end
                    else
                    begin
                        skip_next       = skip_sum[16] ? 16'hFFFF : skip_sum[15:0];
                        held_valid_next = is_low;
                        if (is_low)
                            held_byte_next = rx_byte;
                    end
                end
                PH_HEADER:
                begin
                    serial_next = ser_w;
                    flen_next   = flen_w;
                    hpos_next   = p_inc[3:0];
                    if (p_inc >= {1'b0, hl})
                    begin
                        held_valid_next = 1'b0;
                        if (hdr_ok)
                            phase_next = PH_CODE;
                        else
                        begin
                            phase_next          = PH_HUNT;
                            push                = 1'b1;
                            push_ent.has_status = 1'b1;
                            push_ent.status     = STATUS_HDR_BAD;
                            push_ent.base_index = '0;
                        end
                    end
                end
                PH_CODE:
                begin
                    if (!held_valid_reg)
                    begin
                        held_byte_next  = rx_byte;
                        held_valid_next = 1'b1;
                    end
                    else
                    begin
                        held_valid_next = 1'b0;
                        code_next       = code_w;
                        pleft_next      = pl;
                        ve_next         = '0;
                        bad_next        = bad_w;
                        if (pl == 16'd0)
                        begin
                            phase_next          = PH_HUNT;
                            push                = 1'b1;
                            push_ent.has_status = 1'b1;
                            push_ent.base_index = '0;
                            push_ent.end_code   = code_w;
                            push_ent.status     = (code_w != 16'd0) ? STATUS_RESP_ERR :
                                                  bad_w ? STATUS_BAD_COUNT : STATUS_OK;
                        end
                        else
                            phase_next = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    if (code_reg == 16'd0 && !bad_reg)
                    begin
                        if (cfg.dev_is_bit)
                        begin
                            // High nibble first; a nibble of one means true.
                            push_ent.n_vals = {1'b0, first} + {1'b0, second};
                            push_ent.v0     = {15'd0, rx_byte[7:4] == 4'h1};
                            push_ent.v1     = (rx_byte[3:0] == 4'h1);
                            ve_next         = ve_reg + {8'd0, push_ent.n_vals};
                        end
                        else if (!held_valid_reg)
                        begin
                            held_byte_next  = rx_byte;
                            held_valid_next = 1'b1;
                        end
                        else
                        begin
                            held_valid_next = 1'b0;
                            push_ent.n_vals = 2'd1;
                            push_ent.v0     = {rx_byte, held_byte_reg};
                            ve_next         = ve_plus1[9:0];
                        end
                    end
                    pleft_next = pl_dec;
                    if (pl_dec == 16'd0)
                    begin
                        phase_next          = PH_HUNT;
                        held_valid_next     = 1'b0;
                        push_ent.has_status = 1'b1;
                        push_ent.status     = (code_reg != 16'd0) ? STATUS_RESP_ERR :
                                              bad_reg ? STATUS_BAD_COUNT : STATUS_OK;
                    end
                    push = (push_ent.n_vals != 2'd0) || push_ent.has_status;
                end
                default:
                    phase_next = PH_HUNT;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            held_byte_reg  <= '0;
            held_valid_reg <= 1'b0;
            hpos_reg       <= '0;
            four_reg       <= 1'b0;
            serial_reg     <= '0;
            flen_reg       <= '0;
            pleft_reg      <= '0;
            code_reg       <= '0;
            bad_reg        <= 1'b0;
            ve_reg         <= '0;
            skip_reg       <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
            hpos_reg       <= hpos_next;
            four_reg       <= four_next;
            serial_reg     <= serial_next;
            flen_reg       <= flen_next;
            pleft_reg      <= pleft_next;
            code_reg       <= code_next;
            bad_reg        <= bad_next;
            ve_reg         <= ve_next;
            skip_reg       <= skip_next;
        end
    end

endmodule

FILE: hw/rtl/slmp_rfp_fifo.sv
// ---------------------------------------------------------------------------
// SLMP response parser entry queue
// Short first-in first-out queue between the front end and the back end.
// ---------------------------------------------------------------------------
module slmp_rfp_fifo
    import slmp_rfp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  ent_t push_ent,
    input  logic pop,
    output ent_t pop_ent,
    output logic full,
    output logic empty
);

    ent_t               mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;

    assign full    = (count_reg == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_ent = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_ent;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("entry pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("entry popped from an empty queue");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (FIFO_AW + 1)'(FIFO_DEPTH))
        else $error("queue count beyond its depth");

endmodule

FILE: hw/rtl/slmp_rfp_back.sv
// ---------------------------------------------------------------------------
// SLMP response parser back end
// Unpacks queue entries into single results and drives the output register.
// ---------------------------------------------------------------------------
module slmp_rfp_back
    import slmp_rfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        empty,
    input  ent_t        head_ent,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [15:0] value,
    output logic [9:0]  value_index,
    output logic [1:0]  status,
    output logic [15:0] end_code,
    output logic        frame_type,
    output logic [15:0] skipped_bytes,
    output logic        last
);

    ent_t        cur_reg;
    logic        cur_valid_reg;
    logic [1:0]  sel_reg;

    logic        out_valid_reg;
    logic        kind_reg;
    logic [15:0] value_reg;
    logic [9:0]  index_reg;
    logic [1:0]  status_reg;
    logic [15:0] end_code_reg;
    logic        frame_type_reg;
    logic [15:0] skipped_reg;

    logic [1:0]  total;
    logic        is_status;
    logic        out_load;
    logic        cur_done;

    assign total     = cur_reg.n_vals + {1'b0, cur_reg.has_status};
    assign is_status = (sel_reg >= cur_reg.n_vals);
    assign out_load  = cur_valid_reg && (!out_valid_reg || out_ready);
    assign cur_done  = out_load && (sel_reg + 2'd1 == total);
    assign pop       = !empty && (!cur_valid_reg || cur_done);

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign value         = value_reg;
    assign value_index   = index_reg;
    assign status        = status_reg;
    assign end_code      = end_code_reg;
    assign frame_type    = frame_type_reg;
    assign skipped_bytes = skipped_reg;
    assign last          = kind_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            sel_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                cur_valid_reg <= 1'b1;
                sel_reg       <= '0;
            end
            else if (cur_done)
                cur_valid_reg <= 1'b0;
            else if (out_load)
                sel_reg <= sel_reg + 2'd1;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= head_ent;
        if (out_load)
        begin
            kind_reg       <= is_status;
            value_reg      <= is_status ? 16'd0 :
                              (sel_reg == 2'd0) ? cur_reg.v0 : {15'd0, cur_reg.v1};
            // The status index equals the count of values emitted so far.
            index_reg      <= cur_reg.base_index + {8'd0, sel_reg};
            status_reg     <= is_status ? cur_reg.status : STATUS_OK;
            end_code_reg   <= cur_reg.end_code;
            frame_type_reg <= cur_reg.frame_type;
            skipped_reg    <= cur_reg.skipped;
        end
    end

    a_sel_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (sel_reg < total))
        else $error("result selector beyond the entry's results");

endmodule

FILE: hw/rtl/slmp_response_frame_parser_top.sv
// ---------------------------------------------------------------------------
// SLMP 3E/4E binary response frame parser
// Hunts for response subheaders in a byte stream, checks the header and end
// code, and emits word or bit values followed by one status per frame.
//
//   Channel   Handshake                 Payload
//   rx        rx_valid / rx_ready       rx_byte
//   out       out_valid / out_ready     kind, value, value_index, status,
//                                       end_code, frame_type, skipped_bytes, last
//   config    psel, penable, pwrite     paddr, pwdata, prdata, pready
//
// The front end takes one byte per cycle while the queue is not full, and the
// back end delivers one result per cycle while out_ready is high. A byte that
// gives two or three results (a pair of bit values, or the last values of a
// frame with its status) holds the back end until all are out, so a full queue
// slows a bit payload to the back end's pace; other bytes do not hold it.
// A four-entry queue lets the front end run ahead of a stalled output.
// Reset is asynchronous and active low and returns the parser to hunting.
// ---------------------------------------------------------------------------
module slmp_response_frame_parser_top
    import slmp_rfp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    input  logic              rx_valid,
    output logic              rx_ready,
    input  logic [7:0]        rx_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              kind,
    output logic [15:0]       value,
    output logic [9:0]        value_index,
    output logic [1:0]        status,
    output logic [15:0]       end_code,
    output logic              frame_type,
    output logic [15:0]       skipped_bytes,
    output logic              last
);

    cfg_t cfg;
    logic accept;
    logic push;
    ent_t push_ent;
    logic pop;
    ent_t head_ent;
    logic full;
    logic empty;

    assign rx_ready = !full;
    assign accept   = rx_valid && rx_ready;

    slmp_rfp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    slmp_rfp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .accept   (accept),
        .rx_byte  (rx_byte),
        .push     (push),
        .push_ent (push_ent)
    );

    slmp_rfp_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_ent (push_ent),
        .pop      (pop),
        .pop_ent  (head_ent),
        .full     (full),
        .empty    (empty)
    );

    slmp_rfp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .empty         (empty),
        .head_ent      (head_ent),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .value         (value),
        .value_index   (value_index),
        .status        (status),
        .end_code      (end_code),
        .frame_type    (frame_type),
        .skipped_bytes (skipped_bytes),
        .last          (last)
    );

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Testbench for the SLMP response frame parser
// Feeds byte streams of 3E and 4E response frames, with noise, broken headers
// and bad counts, through the rx channel under random back-pressure. A local
// frame decoder predicts each result, and every output transaction is checked
// field by field against the oldest outstanding prediction.
// ---------------------------------------------------------------------------
module testbench;
    import slmp_rfp_pkg::*;

    typedef struct packed {
        logic        kind;
        logic [15:0] value;
        logic [9:0]  value_index;
        logic [1:0]  status;
        logic [15:0] end_code;
        logic        frame_type;
        logic [15:0] skipped;
        logic        last;
    } frame_result_t;

    // A stimulus byte; where typed is set, res replaces the decoder's answer.
    typedef struct packed {
        logic [7:0]    data;
        logic          typed;
        frame_result_t res;
    } directed_row_t;

    typedef enum logic [1:0] {HUNTING, IN_HEADER, IN_CODE, IN_PAYLOAD} parse_phase_t;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 64;
    localparam int SETTLE_CYCLES  = 10;
    localparam int PHASE_BYTES    = 24;

    localparam frame_result_t NO_RESULT = '0;
    localparam frame_result_t HDR_BAD_3E =
        '{1'b1, 16'h0000, 10'd0, STATUS_HDR_BAD, 16'h0000, 1'b0, 16'd2, 1'b1};
    localparam frame_result_t RESP_ERR_4E =
        '{1'b1, 16'h0000, 10'd0, STATUS_RESP_ERR, 16'h1234, 1'b1, 16'd2, 1'b1};

    // Runs on the reset register values.
    localparam directed_row_t DIRECTED_ROWS [26] = '{
        '{8'hFF, 1'b0, NO_RESULT},
        // A doubled low byte, then a 3E subheader
        '{8'hD0, 1'b0, NO_RESULT},
        '{8'hD0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, NO_RESULT},
        '{8'h80, 1'b0, NO_RESULT},
        '{8'h7F, 1'b0, NO_RESULT},
        '{8'h01, 1'b0, NO_RESULT},
        // Length word 0xFFFF is far beyond the packet limit.
        '{8'hFF, 1'b0, NO_RESULT},
        '{8'hFF, 1'b1, HDR_BAD_3E},
        // A 4E frame with matching serial, empty payload and a nonzero end code
        '{8'hD4, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h55, 1'b0, NO_RESULT},
        '{8'hAA, 1'b0, NO_RESULT},
        '{8'h0F, 1'b0, NO_RESULT},
        '{8'hF0, 1'b0, NO_RESULT},
        '{8'h33, 1'b0, NO_RESULT},
        '{8'hCC, 1'b0, NO_RESULT},
        '{8'h01, 1'b0, NO_RESULT},
        '{8'h02, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h34, 1'b0, NO_RESULT},
        '{8'h12, 1'b1, RESP_ERR_4E}
    };

    localparam cfg_t PHASE_CFG [6] = '{
        '{16'h00D0, 16'h00D4, 16'hFFFF, 10'd1,    1'b0, 1'b0},
        '{16'h00D0, 16'h00D4, 16'h1234, 10'd4,    1'b0, 1'b0},
        '{16'h5A50, 16'h5A54, 16'h0000, 10'd5,    1'b1, 1'b0},
        '{16'h00D0, 16'h00D4, 16'h0001, 10'd960,  1'b0, 1'b0},
        '{16'h0000, 16'hFFFF, 16'h8000, 10'd1023, 1'b1, 1'b1},
        '{16'hFFFF, 16'h0000, 16'h00FF, 10'd3,    1'b1, 1'b0}
    };

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              rx_valid = 1'b0;
    logic              rx_ready;
    logic [7:0]        rx_byte = 8'h00;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              kind;
    logic [15:0]       value;
    logic [9:0]        value_index;
    logic [1:0]        status;
    logic [15:0]       end_code;
    logic              frame_type;
    logic [15:0]       skipped_bytes;
    logic              last;

    directed_row_t     cur_row = '0;
    frame_result_t     results_due [$];
    logic [7:0]        byte_plan [$];
    int                errors = 0;
    bit                idle_on = 1'b1;
    bit                hold_req = 1'b0;

    // Decoder state and its copy of the registers
    cfg_t              cfg = '{SUB_3E_RESET, SUB_4E_RESET, 16'h0000, 10'd0, 1'b0, 1'b0};
    parse_phase_t      phase_now = HUNTING;
    logic [7:0]        held = 8'h00;
    bit                held_ok = 1'b0;
    int                hdr_pos = 0;
    bit                four_e = 1'b0;
    logic [15:0]       serial_rx = '0;
    logic [15:0]       frame_len = '0;
    logic [15:0]       left = '0;
    logic [15:0]       code_rx = '0;
    bit                drop = 1'b0;
    logic [9:0]        emitted = '0;
    logic [15:0]       skips = '0;

    slmp_response_frame_parser_top dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void push_result(logic k, logic [15:0] v, logic [9:0] idx,
                                        logic [1:0] st, logic lst);
        results_due.push_back(frame_result_t'{k, v, idx, st, code_rx, four_e, skips, lst});
    endfunction

    function automatic void push_value(logic [15:0] v);
        push_result(1'b0, v, emitted, STATUS_OK, 1'b0);
        emitted++;
    endfunction

    function automatic void close_frame();
        logic [1:0] st;
        st = (code_rx != 0) ? STATUS_RESP_ERR : (drop ? STATUS_BAD_COUNT : STATUS_OK);
        push_result(1'b1, 16'h0000, emitted, st, 1'b1);
        phase_now = HUNTING;
        held_ok = 1'b0;
    endfunction

    function automatic void parse_byte(logic [7:0] b);
        logic [15:0] w;
        int          hl;
        int          la;
        bit          cnt_bad;
        w = {b, held};
        case (phase_now)
            HUNTING:
            begin
                if (held_ok) begin
                    if (w == cfg.sub_4e || w == cfg.sub_3e) begin
                        // The 4E word wins when both subheaders are equal.
                        four_e = (w == cfg.sub_4e);
                        held_ok = 1'b0;
                        hdr_pos = 2;
                        serial_rx = '0;
                        frame_len = '0;
                        code_rx = '0;
                        left = '0;
                        drop = 1'b0;
                        emitted = '0;
                        phase_now = IN_HEADER;
                        return;
                    end
                    if (skips != 16'hFFFF) skips++;
                    held_ok = 1'b0;
                end
                if (b == cfg.sub_3e[7:0] || b == cfg.sub_4e[7:0]) begin
                    held = b;
                    held_ok = 1'b1;
                end
                else if (skips != 16'hFFFF) begin
                    skips++;
                end
            end
            IN_HEADER:
            begin
                hl = four_e ? HDR_LEN_4E : HDR_LEN_3E;
                la = four_e ? LEN_AT_4E : LEN_AT_3E;
                if (four_e && hdr_pos == 2) serial_rx[7:0] = b;
                if (four_e && hdr_pos == 3) serial_rx[15:8] = b;
                if (hdr_pos == la) frame_len[7:0] = b;
                if (hdr_pos == la + 1) frame_len[15:8] = b;
                hdr_pos++;
                if (hdr_pos >= hl) begin
                    held_ok = 1'b0;
                    if ((four_e && serial_rx != cfg.exp_serial) || frame_len < 2
                        || frame_len > MAX_PACKET) begin
                        push_result(1'b1, 16'h0000, 10'd0, STATUS_HDR_BAD, 1'b1);
                        phase_now = HUNTING;
                    end
                    else begin
                        phase_now = IN_CODE;
                    end
                end
            end
            IN_CODE:
            begin
                cnt_bad = cfg.req_count == 0 || cfg.req_count > MAX_VALUES;
                if (!held_ok) begin
                    held = b;
                    held_ok = 1'b1;
                end
                else begin
                    held_ok = 1'b0;
                    code_rx = w;
                    left = frame_len - 16'd2;
                    emitted = '0;
                    if (code_rx != 0)
                        drop = 1'b0;
                    else if (cfg.batch_write)
                        drop = left != 0;
                    else if (cfg.dev_is_bit)
                        drop = cnt_bad || int'(left) < (int'(cfg.req_count) + 1) / 2;
                    else
                        drop = left[0] || cnt_bad || int'(left) != 2 * int'(cfg.req_count);
                    if (left == 0)
                        close_frame();
                    else
                        phase_now = IN_PAYLOAD;
                end
            end
            default:
            begin
                if (code_rx == 0 && !drop) begin
                    if (cfg.dev_is_bit) begin
                        // High nibble first; only a nibble of one counts as set.
                        if (emitted < cfg.req_count) push_value(16'(b[7:4] == 4'h1));
                        if (emitted < cfg.req_count) push_value(16'(b[3:0] == 4'h1));
                    end
                    else if (!held_ok) begin
                        held = b;
                        held_ok = 1'b1;
                    end
                    else begin
                        held_ok = 1'b0;
                        push_value(w);
                    end
                end
                left--;
                if (left == 0) close_frame();
            end
        endcase
    endfunction

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin : scoreboard
        int            depth;
        frame_result_t want;
        if (rst_n) begin
            if (rx_valid && rx_ready) begin
                depth = results_due.size();
                parse_byte(rx_byte);
                if (cur_row.typed) begin
                    while (results_due.size() > depth) void'(results_due.pop_back());
                    results_due.push_back(cur_row.res);
                end
            end
            if (out_valid && out_ready) begin
                if (results_due.size() == 0) begin
                    $display("%0t ns: result with none outstanding, expected nothing, actual %h",
                             $time, {kind, value, value_index, status, end_code, frame_type,
                                     skipped_bytes, last});
                    errors++;
                end
                else begin
                    want = results_due.pop_front();
                    check_field("kind", want.kind, kind);
                    check_field("value", want.value, value);
                    check_field("value_index", want.value_index, value_index);
                    check_field("status", want.status, status);
                    check_field("end_code", want.end_code, end_code);
                    check_field("frame_type", want.frame_type, frame_type);
                    check_field("skipped_bytes", want.skipped, skipped_bytes);
                    check_field("last", want.last, last);
                end
            end
        end
    end

    // Output side: short random stalls, or one long hold-off on request.
    initial
    begin
        forever begin
            @(posedge clk);
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                out_ready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 5) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (rx_valid && rx_ready) || (out_valid && out_ready)
                || (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("TEST FAILED");
        $finish;
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_AW'({idx, 2'b00});
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_SUB_3E:      cfg.sub_3e = data[15:0];
            REG_SUB_4E:      cfg.sub_4e = data[15:0];
            REG_EXP_SERIAL:  cfg.exp_serial = data[15:0];
            REG_REQ_COUNT:   cfg.req_count = data[9:0];
            REG_DEV_IS_BIT:  cfg.dev_is_bit = data[0];
            REG_BATCH_WRITE: cfg.batch_write = data[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic program_config(cfg_t c);
        write_reg(REG_SUB_3E, 32'(c.sub_3e));
        write_reg(REG_SUB_4E, 32'(c.sub_4e));
        write_reg(REG_EXP_SERIAL, 32'(c.exp_serial));
        write_reg(REG_REQ_COUNT, 32'(c.req_count));
        write_reg(REG_DEV_IS_BIT, 32'(c.dev_is_bit));
        write_reg(REG_BATCH_WRITE, 32'(c.batch_write));
    endtask

    function automatic logic [3:0] bit_nibble();
        int r;
        r = $urandom_range(0, 7);
        if (r < 3) return 4'h1;
        if (r < 5) return 4'h0;
        return 4'($urandom_range(0, 15));
    endfunction

    // Appends one frame built for the current registers, mostly well formed.
    task automatic add_frame();
        bit          four;
        bit          bad_hdr;
        int          roll;
        int          plen;
        int          need;
        int          len_at;
        logic [15:0] sub;
        logic [15:0] ser;
        logic [15:0] len;
        logic [15:0] code;
        four = 1'($urandom_range(0, 1));
        roll = $urandom_range(0, 99);
        bad_hdr = (four && roll < 8) || (roll >= 90 && roll < 96);
        repeat ($urandom_range(0, 2)) byte_plan.push_back(8'($urandom_range(0, 255)));
        sub = four ? cfg.sub_4e : cfg.sub_3e;
        byte_plan.push_back(sub[7:0]);
        byte_plan.push_back(sub[15:8]);
        len_at = four ? LEN_AT_4E : LEN_AT_3E;
        if (four) begin
            ser = cfg.exp_serial;
            if (roll < 8) ser = ser ^ 16'($urandom_range(1, 65535));
            byte_plan.push_back(ser[7:0]);
            byte_plan.push_back(ser[15:8]);
        end
        for (int p = four ? 4 : 2; p < len_at; p++)
            byte_plan.push_back(8'($urandom_range(0, 255)));
        if (cfg.batch_write) begin
            plen = (roll % 5 == 0) ? $urandom_range(1, 4) : 0;
        end
        else begin
            need = cfg.dev_is_bit ? (int'(cfg.req_count) + 1) / 2 : 2 * int'(cfg.req_count);
            if (cfg.req_count == 0 || cfg.req_count > MAX_VALUES || need > 24)
                plen = $urandom_range(0, 8);
            else if (roll % 4 == 0)
                plen = $urandom_range(0, need + 3);
            else
                plen = need;
        end
        len = 16'(plen + 2);
        case (roll)
            90: len = 16'd0;
            91: len = 16'd1;
            92: len = 16'(MAX_PACKET + 1);
            93: len = 16'hFFFF;
            94, 95: len = 16'($urandom_range(MAX_PACKET + 1, 65535));
            default: ;
        endcase
        byte_plan.push_back(len[7:0]);
        byte_plan.push_back(len[15:8]);
        if (bad_hdr) return;
        code = 16'h0000;
        if (roll == 80) code = 16'hFFFF;
        else if (roll > 80 && roll < 90) code = 16'($urandom_range(1, 65535));
        byte_plan.push_back(code[7:0]);
        byte_plan.push_back(code[15:8]);
        for (int i = 0; i < plen; i++) begin
            if (cfg.dev_is_bit)
                byte_plan.push_back({bit_nibble(), bit_nibble()});
            else
                byte_plan.push_back(8'($urandom_range(0, 255)));
        end
        // Now and then the frame is cut short and the next one runs into it.
        if (roll >= 97)
            repeat ($urandom_range(1, 3)) void'(byte_plan.pop_back());
    endtask

    task automatic send_row(directed_row_t r);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            rx_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte <= r.data;
        cur_row <= r;
        @(posedge clk);
        while (!rx_ready) @(posedge clk);
    endtask

    task automatic send_plan(int first, int stop);
        for (int i = first; i < stop; i++)
            send_row(directed_row_t'{byte_plan[i], 1'b0, NO_RESULT});
    endtask

    // The first wait lets the scoreboard take in the last accepted byte.
    task automatic await_results();
        rx_valid <= 1'b0;
        @(posedge clk);
        while (results_due.size() != 0) @(posedge clk);
    endtask

    task automatic drain();
        await_results();
        // Bytes that give no result may still be in flight.
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        cfg_t next_cfg;
        int   half;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < 26; i++)
            send_row(DIRECTED_ROWS[i]);
        drain();
        for (int ph = 0; ph < 7; ph++) begin
            if (ph < 6) begin
                next_cfg = PHASE_CFG[ph];
            end
            else begin
                next_cfg.sub_3e = 16'($urandom_range(0, 65535));
                next_cfg.sub_4e = 16'($urandom_range(0, 65535));
                next_cfg.exp_serial = 16'($urandom_range(0, 65535));
                next_cfg.req_count = 10'($urandom_range(1, 6));
                next_cfg.dev_is_bit = 1'($urandom_range(0, 1));
                next_cfg.batch_write = 1'b0;
            end
            program_config(next_cfg);
            // The final stretch runs at full rate on both sides.
            idle_on = (ph != 6);
            byte_plan.delete();
            while (byte_plan.size() < PHASE_BYTES) add_frame();
            if (ph == 2) hold_req = 1'b1;
            if (ph == 3) begin
                half = byte_plan.size() / 2;
                send_plan(0, half);
                await_results();
                send_plan(half, byte_plan.size());
            end
            else begin
                send_plan(0, byte_plan.size());
            end
            drain();
        end
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
